// ===== rtl/core/mfd_pkg.sv =====
// Shared types, constants, microcode program and helpers for the feedback decoder.
`timescale 1ns / 1ps
package mfd_pkg;

  // Velocity history ring. The mean divides by a shift, so the depth is a power of two.
  localparam int unsigned HistDepth = 8;
  localparam int unsigned HistIdxW  = $clog2(HistDepth);
  localparam int unsigned TotW      = 32 + HistIdxW;

  // Code widths of the packed frame fields.
  localparam int unsigned PosBits  = 16;
  localparam int unsigned CodeBits = 12;

  // Datapath widths.
  localparam int unsigned ProdW = 55;
  localparam int unsigned RemW  = 49;
  localparam int unsigned QuoW  = 33;
  localparam int unsigned SqW   = QuoW + 1;
  localparam int unsigned StepW = 5;

  localparam logic [RemW-1:0] PosMask  = RemW'((64'd1 << PosBits) - 64'd1);
  localparam logic [RemW-1:0] CodeMask = RemW'((64'd1 << CodeBits) - 64'd1);

  // 180/pi in Q16.16, rounded.
  localparam logic signed [22:0] RadToDeg = 23'sd3754936;

  // Configuration reset values, Q16.16.
  localparam logic signed [31:0] PosMinRst    = -32'sd819200;
  localparam logic signed [31:0] PosMaxRst    = 32'sd819200;
  localparam logic signed [31:0] VelMinRst    = -32'sd4259840;
  localparam logic signed [31:0] VelMaxRst    = 32'sd4259840;
  localparam logic signed [31:0] TrqMinRst    = -32'sd1179648;
  localparam logic signed [31:0] TrqMaxRst    = 32'sd1179648;
  localparam logic signed [31:0] SpdOffsetRst = 32'sd0;

  typedef enum logic [2:0] {
    REG_POS_MIN,
    REG_POS_MAX,
    REG_VEL_MIN,
    REG_VEL_MAX,
    REG_TORQUE_MIN,
    REG_TORQUE_MAX,
    REG_SPEED_OFFSET
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_MUL,     // product of raw code and range span
    OP_ABS,     // split product into sign and magnitude, clear quotient
    OP_DSTEP,   // one reduction step of the divide by 2^k-1, repeats while needed
    OP_FIX,     // final quotient correction
    OP_SIGN,    // restore sign of quotient
    OP_ADD,     // add range minimum and saturate
    OP_BIAS,    // subtract velocity bias and saturate
    OP_RING,    // update history ring and running total
    OP_MEAN,    // divide running total by depth
    OP_DEGMUL,  // multiply by 180/pi
    OP_DEGSH,   // scale back and saturate
    OP_DONE     // hand result to output register
  } op_e;

  typedef enum logic [1:0] {
    CH_POS,
    CH_VEL,
    CH_TRQ
  } chan_e;

  typedef struct packed {
    op_e   op;
    chan_e chan;
  } ctrl_t;

  typedef struct packed {
    logic signed [31:0] position_rad;
    logic signed [31:0] velocity_mean;
    logic signed [31:0] torque_value;
    logic signed [31:0] angle_degrees;
    logic signed [31:0] speed_degrees;
  } result_t;

  // Control store. For the degree steps, the position channel selects the position
  // and the velocity channel selects the mean.
  function automatic ctrl_t ucode_rom(input logic [StepW-1:0] pc);
    ctrl_t w;
    unique case (pc)
      5'd0:    w = '{OP_MUL,    CH_POS};
      5'd1:    w = '{OP_ABS,    CH_POS};
      5'd2:    w = '{OP_DSTEP,  CH_POS};
      5'd3:    w = '{OP_FIX,    CH_POS};
      5'd4:    w = '{OP_SIGN,   CH_POS};
      5'd5:    w = '{OP_ADD,    CH_POS};
      5'd6:    w = '{OP_MUL,    CH_VEL};
      5'd7:    w = '{OP_ABS,    CH_VEL};
      5'd8:    w = '{OP_DSTEP,  CH_VEL};
      5'd9:    w = '{OP_FIX,    CH_VEL};
      5'd10:   w = '{OP_SIGN,   CH_VEL};
      5'd11:   w = '{OP_ADD,    CH_VEL};
      5'd12:   w = '{OP_MUL,    CH_TRQ};
      5'd13:   w = '{OP_ABS,    CH_TRQ};
      5'd14:   w = '{OP_DSTEP,  CH_TRQ};
      5'd15:   w = '{OP_FIX,    CH_TRQ};
      5'd16:   w = '{OP_SIGN,   CH_TRQ};
      5'd17:   w = '{OP_ADD,    CH_TRQ};
      5'd18:   w = '{OP_BIAS,   CH_VEL};
      5'd19:   w = '{OP_RING,   CH_VEL};
      5'd20:   w = '{OP_MEAN,   CH_VEL};
      5'd21:   w = '{OP_DEGMUL, CH_POS};
      5'd22:   w = '{OP_DEGSH,  CH_POS};
      5'd23:   w = '{OP_DEGMUL, CH_VEL};
      5'd24:   w = '{OP_DEGSH,  CH_VEL};
      default: w = '{OP_DONE,   CH_POS};
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mfd_datapath.sv =====
// Datapath of the feedback decoder: configuration, scaling, history ring and degree conversion.
`timescale 1ns / 1ps
module mfd_datapath import mfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        capture_i,
  input  logic [7:0]  frame_byte1_i,
  input  logic [7:0]  frame_byte2_i,
  input  logic [7:0]  frame_byte3_i,
  input  logic [7:0]  frame_byte4_i,
  input  logic [7:0]  frame_byte5_i,
  input  ctrl_t       ctrl_i,
  output logic        loop_o,
  output result_t     res_o
);

  // Configuration and ring state.
  logic signed [31:0] pos_min_q, pos_max_q, vel_min_q, vel_max_q;
  logic signed [31:0] trq_min_q, trq_max_q, offset_q;
  logic signed [31:0] hist_q [HistDepth];
  logic [HistIdxW-1:0] ptr_q;
  logic signed [TotW-1:0] total_q;

  // Working registers.
  logic [15:0] raw_pos_q;
  logic [11:0] raw_vel_q, raw_trq_q;
  logic signed [ProdW-1:0] prod_q;
  logic [RemW-1:0] rem_q;
  logic [QuoW-1:0] quo_q;
  logic neg_q;
  logic signed [SqW-1:0] sq_q;
  logic signed [31:0] pos_q, vel_q, trq_q, corr_q, mean_q, angle_q, speed_q;

  logic [15:0] sel_raw;
  logic signed [31:0] sel_lo, sel_hi, deg_src;
  logic signed [32:0] span, mul_x;
  logic signed [22:0] mul_y;
  logic signed [55:0] prod_full;
  logic wide;
  logic [RemW-1:0] rem_hi, rem_lo, full_scale;
  logic signed [ProdW-1:0] prod_mag;
  logic signed [SqW-1:0] quo_ext;
  logic signed [34:0] add_sum;
  logic signed [31:0] add_val, deg_val;
  logic signed [32:0] bias_diff;
  logic signed [TotW-1:0] total_d, tot_adj, mean_sh;
  logic signed [ProdW-1:0] deg_adj, deg_sh;

  always_comb begin
    case (ctrl_i.chan)
      CH_VEL: begin
        sel_raw = {4'd0, raw_vel_q};
        sel_lo  = vel_min_q;
        sel_hi  = vel_max_q;
      end
      CH_TRQ: begin
        sel_raw = {4'd0, raw_trq_q};
        sel_lo  = trq_min_q;
        sel_hi  = trq_max_q;
      end
      default: begin
        sel_raw = raw_pos_q;
        sel_lo  = pos_min_q;
        sel_hi  = pos_max_q;
      end
    endcase
    wide = (ctrl_i.chan == CH_POS);

    span    = 33'(sel_hi) - 33'(sel_lo);
    deg_src = wide ? pos_q : mean_q;
    if (ctrl_i.op == OP_DEGMUL) begin
      mul_x = 33'(deg_src);
      mul_y = RadToDeg;
    end else begin
      mul_x = span;
      mul_y = $signed({7'd0, sel_raw});
    end
    prod_full = mul_x * mul_y;

    // Divide by 2^k-1: x = a*2^k + b = a*(2^k-1) + (a+b).
    rem_hi     = wide ? (rem_q >> PosBits) : (rem_q >> CodeBits);
    rem_lo     = rem_q & (wide ? PosMask : CodeMask);
    full_scale = wide ? PosMask : CodeMask;
    loop_o     = (rem_hi != '0);

    prod_mag = prod_q[ProdW-1] ? -prod_q : prod_q;
    quo_ext  = $signed({1'b0, quo_q});

    add_sum = 35'(sel_lo) + 35'(sq_q);
    add_val = sat32(64'(add_sum));

    bias_diff = 33'(vel_q) - 33'(offset_q);
    total_d   = total_q + TotW'(corr_q) - TotW'(hist_q[ptr_q]);

    // Division by the depth truncates toward zero.
    tot_adj = total_q + (total_q[TotW-1] ? TotW'(HistDepth - 1) : TotW'(0));
    mean_sh = tot_adj >>> HistIdxW;

    deg_adj = prod_q + (prod_q[ProdW-1] ? ProdW'(65535) : ProdW'(0));
    deg_sh  = deg_adj >>> 16;
    deg_val = sat32(64'(deg_sh));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_min_q <= PosMinRst;
      pos_max_q <= PosMaxRst;
      vel_min_q <= VelMinRst;
      vel_max_q <= VelMaxRst;
      trq_min_q <= TrqMinRst;
      trq_max_q <= TrqMaxRst;
      offset_q  <= SpdOffsetRst;
      for (int i = 0; i < HistDepth; i++) begin
        hist_q[i] <= '0;
      end
      ptr_q   <= '0;
      total_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_POS_MIN:      pos_min_q <= cfg_wdata_i;
          REG_POS_MAX:      pos_max_q <= cfg_wdata_i;
          REG_VEL_MIN:      vel_min_q <= cfg_wdata_i;
          REG_VEL_MAX:      vel_max_q <= cfg_wdata_i;
          REG_TORQUE_MIN:   trq_min_q <= cfg_wdata_i;
          REG_TORQUE_MAX:   trq_max_q <= cfg_wdata_i;
          REG_SPEED_OFFSET: offset_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (ctrl_i.op == OP_RING) begin
        total_q       <= total_d;
        hist_q[ptr_q] <= corr_q;
        ptr_q <= (ptr_q == HistIdxW'(HistDepth - 1)) ? '0 : ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      raw_pos_q <= {frame_byte1_i, frame_byte2_i};
      raw_vel_q <= {frame_byte3_i, frame_byte4_i[7:4]};
      raw_trq_q <= {frame_byte4_i[3:0], frame_byte5_i};
    end
    case (ctrl_i.op) inside
      OP_MUL, OP_DEGMUL: prod_q <= prod_full[ProdW-1:0];
      OP_ABS: begin
        neg_q <= prod_q[ProdW-1];
        rem_q <= prod_mag[RemW-1:0];
        quo_q <= '0;
      end
      OP_DSTEP: begin
        rem_q <= rem_hi + rem_lo;
        quo_q <= quo_q + rem_hi[QuoW-1:0];
      end
      OP_FIX: begin
        if (rem_q >= full_scale) begin
          quo_q <= quo_q + 1'b1;
        end
      end
      OP_SIGN: sq_q <= neg_q ? -quo_ext : quo_ext;
      OP_ADD: begin
        case (ctrl_i.chan)
          CH_VEL:  vel_q <= add_val;
          CH_TRQ:  trq_q <= add_val;
          default: pos_q <= add_val;
        endcase
      end
      OP_BIAS: corr_q <= sat32(64'(bias_diff));
      OP_MEAN: mean_q <= sat32(64'(mean_sh));
      OP_DEGSH: begin
        if (wide) begin
          angle_q <= deg_val;
        end else begin
          speed_q <= deg_val;
        end
      end
      default: ;
    endcase
  end

  assign res_o = '{
    position_rad:  pos_q,
    velocity_mean: mean_q,
    torque_value:  trq_q,
    angle_degrees: angle_q,
    speed_degrees: speed_q
  };

endmodule

// ===== rtl/core/motor_feedback_decoder_with_average.sv =====
// Top level of the motor feedback decoder: microcode sequencer, handshakes and output register.
`timescale 1ns / 1ps
// Decodes bytes 1 to 5 of a motor feedback frame into position, torque and a moving-average
// velocity in Q16.16, plus position and mean speed in degrees.
// Input channel: in_valid_i with the five frame bytes; a transfer happens when in_valid_i is
// high and in_stall_o is low. Output channel: out_valid_o with the five results; the receiver
// holds out_stall_i high to keep the result in place.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 to 6) at the clock
// edge; indexes above 6 are ignored. Write only while no frame is in progress.
// Each frame is run by a 26-step microprogram over one shared multiplier and adder datapath.
// Each of the three divide-by-full-scale loops repeats its reduction step until the remainder
// fits. One frame is processed at a time: in_stall_o is high from the input transfer until
// the result has been moved into the output register.
// A finished result waits in the output register while the next frame is already taken.
// If the output register is still occupied when a frame finishes, the sequencer holds on
// its last step until the receiver takes the previous result.
// Reset clears the history ring, its pointer and running total, loads the default ranges
// and empties the output register.
module motor_feedback_decoder_with_average import mfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         frame_byte1_i,
  input  logic [7:0]         frame_byte2_i,
  input  logic [7:0]         frame_byte3_i,
  input  logic [7:0]         frame_byte4_i,
  input  logic [7:0]         frame_byte5_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] position_rad_o,
  output logic signed [31:0] velocity_mean_o,
  output logic signed [31:0] torque_value_o,
  output logic signed [31:0] angle_degrees_o,
  output logic signed [31:0] speed_degrees_o
);

  logic             busy_q;
  logic [StepW-1:0] pc_q;
  logic             out_valid_q;
  result_t          out_q;
  ctrl_t            ctrl;
  ctrl_t            dp_ctrl;
  logic             loop;
  logic             accept;
  logic             out_free;
  result_t          res;

  assign accept   = in_valid_i && !busy_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ctrl     = ucode_rom(pc_q);
  assign dp_ctrl  = busy_q ? ctrl : ctrl_t'{OP_DONE, CH_POS};

  mfd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .capture_i     (accept),
    .frame_byte1_i (frame_byte1_i),
    .frame_byte2_i (frame_byte2_i),
    .frame_byte3_i (frame_byte3_i),
    .frame_byte4_i (frame_byte4_i),
    .frame_byte5_i (frame_byte5_i),
    .ctrl_i        (dp_ctrl),
    .loop_o        (loop),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        busy_q <= 1'b1;
        pc_q   <= '0;
      end else if (busy_q) begin
        unique case (ctrl.op)
          // The divide step repeats until the remainder fits in k bits.
          OP_DSTEP: begin
            if (!loop) begin
              pc_q <= pc_q + 1'b1;
            end
          end
          OP_DONE: begin
            if (out_free) begin
              out_q       <= res;
              out_valid_q <= 1'b1;
              busy_q      <= 1'b0;
              pc_q        <= '0;
            end
          end
          default: pc_q <= pc_q + 1'b1;
        endcase
      end
    end
  end

  assign in_stall_o      = busy_q;
  assign out_valid_o     = out_valid_q;
  assign position_rad_o  = out_q.position_rad;
  assign velocity_mean_o = out_q.velocity_mean;
  assign torque_value_o  = out_q.torque_value;
  assign angle_degrees_o = out_q.angle_degrees;
  assign speed_degrees_o = out_q.speed_degrees;

endmodule
